// ----- design/afs_pkg.sv -----
package afs_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int TOL_WIDTH       = 16;
   localparam int OUT_POS_WIDTH   = 16;
   localparam int MODE_CODE_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_POSITION   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COARSE_STEP    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FINE_STEP      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TOLERANCE = 2'd3;

   localparam logic [CSR_DATA_WIDTH-1:0] END_POSITION_RESET   = 16'd10000;
   localparam logic [CSR_DATA_WIDTH-1:0] COARSE_STEP_RESET    = 16'd500;
   localparam logic [CSR_DATA_WIDTH-1:0] FINE_STEP_RESET      = 16'd50;
   localparam logic [TOL_WIDTH-1:0]      HOLD_TOLERANCE_RESET = 16'd6554;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_STOP  = 1'b1;

   localparam logic [MODE_CODE_WIDTH-1:0] MODE_CODE_NOT_FOCUSED = 3'd0;
   localparam logic [MODE_CODE_WIDTH-1:0] MODE_CODE_COARSE      = 3'd1;
   localparam logic [MODE_CODE_WIDTH-1:0] MODE_CODE_FINE        = 3'd2;
   localparam logic [MODE_CODE_WIDTH-1:0] MODE_CODE_HOLDING     = 3'd3;
   localparam logic [MODE_CODE_WIDTH-1:0] MODE_CODE_REFOCUS     = 3'd4;

   typedef enum logic [4:0] {
      MODE_NOT_FOCUSED = 5'b00001,
      MODE_COARSE      = 5'b00010,
      MODE_FINE        = 5'b00100,
      MODE_HOLDING     = 5'b01000,
      MODE_REFOCUS     = 5'b10000
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     second_set;
   } search_ctrl_type;

   function automatic logic [MODE_CODE_WIDTH-1:0] mode_code(input mode_type m);
      logic [MODE_CODE_WIDTH-1:0] code;
      case (m)
         MODE_COARSE:  code = MODE_CODE_COARSE;
         MODE_FINE:    code = MODE_CODE_FINE;
         MODE_HOLDING: code = MODE_CODE_HOLDING;
         MODE_REFOCUS: code = MODE_CODE_REFOCUS;
         default:      code = MODE_CODE_NOT_FOCUSED;
      endcase
      return code;
   endfunction

endpackage

// ----- design/afs_hold_window.sv -----
module afs_hold_window #(
   parameter int SHARPNESS_WIDTH = 32
) (
   input  logic [SHARPNESS_WIDTH-1:0]     sharpness,
   input  logic [SHARPNESS_WIDTH-1:0]     peak_sharpness,
   input  logic [afs_pkg::TOL_WIDTH-1:0]  hold_tolerance,
   output logic                           outside
);

   localparam int PROD_WIDTH = SHARPNESS_WIDTH + afs_pkg::TOL_WIDTH;

   logic [SHARPNESS_WIDTH-1:0] diff;
   logic [PROD_WIDTH-1:0]      diff_scaled;
   logic [PROD_WIDTH-1:0]      limit;

   always_comb begin
      if (sharpness >= peak_sharpness) begin
         diff = sharpness - peak_sharpness;
      end else begin
         diff = peak_sharpness - sharpness;
      end
   end

   assign diff_scaled = {diff, {afs_pkg::TOL_WIDTH{1'b0}}};
   assign limit       = PROD_WIDTH'(peak_sharpness) * PROD_WIDTH'(hold_tolerance);
   assign outside     = diff_scaled > limit;

endmodule

// ----- design/afs_step.sv -----
module afs_step #(
   parameter int POSITION_WIDTH  = 16,
   parameter int SHARPNESS_WIDTH = 32
) (
   input  logic                          opcode,
   input  logic [SHARPNESS_WIDTH-1:0]    sharpness,
   input  logic [POSITION_WIDTH-1:0]     lens_position,
   input  logic [POSITION_WIDTH-1:0]     end_position,
   input  logic [POSITION_WIDTH-1:0]     coarse_step,
   input  logic [POSITION_WIDTH-1:0]     fine_step,
   input  logic [afs_pkg::TOL_WIDTH-1:0] hold_tolerance,
   input  afs_pkg::search_ctrl_type      ctrl,
   input  logic [SHARPNESS_WIDTH-1:0]    first_sharp,
   input  logic [POSITION_WIDTH-1:0]     first_pos,
   input  logic [SHARPNESS_WIDTH-1:0]    second_sharp,
   input  logic [POSITION_WIDTH-1:0]     second_pos,
   input  logic [SHARPNESS_WIDTH-1:0]    peak_sharp,
   input  logic [POSITION_WIDTH-1:0]     peak_pos,
   output afs_pkg::search_ctrl_type      ctrl_next,
   output logic [SHARPNESS_WIDTH-1:0]    first_sharp_next,
   output logic [POSITION_WIDTH-1:0]     first_pos_next,
   output logic [SHARPNESS_WIDTH-1:0]    second_sharp_next,
   output logic [POSITION_WIDTH-1:0]     second_pos_next,
   output logic [SHARPNESS_WIDTH-1:0]    peak_sharp_next,
   output logic [POSITION_WIDTH-1:0]     peak_pos_next,
   output logic                          move_valid,
   output logic [POSITION_WIDTH-1:0]     move_target
);

   logic [POSITION_WIDTH:0]   coarse_sum;
   logic [POSITION_WIDTH:0]   fine_sum;
   logic [POSITION_WIDTH-1:0] coarse_next_pos;
   logic [POSITION_WIDTH-1:0] fine_next_pos;
   logic [POSITION_WIDTH-1:0] swap_pos;
   logic                      hold_outside;

   assign coarse_sum      = {1'b0, lens_position} + {1'b0, coarse_step};
   assign fine_sum        = {1'b0, lens_position} + {1'b0, fine_step};
   assign coarse_next_pos = coarse_sum[POSITION_WIDTH] ? {POSITION_WIDTH{1'b1}}
                                                       : coarse_sum[POSITION_WIDTH-1:0];
   assign fine_next_pos   = fine_sum[POSITION_WIDTH] ? {POSITION_WIDTH{1'b1}}
                                                     : fine_sum[POSITION_WIDTH-1:0];

   afs_hold_window #(
      .SHARPNESS_WIDTH (SHARPNESS_WIDTH)
   ) u_hold_window (
      .sharpness      (sharpness),
      .peak_sharpness (peak_sharp),
      .hold_tolerance (hold_tolerance),
      .outside        (hold_outside)
   );

   always_comb begin
      ctrl_next         = ctrl;
      first_sharp_next  = first_sharp;
      first_pos_next    = first_pos;
      second_sharp_next = second_sharp;
      second_pos_next   = second_pos;
      peak_sharp_next   = peak_sharp;
      peak_pos_next     = peak_pos;
      move_valid        = 1'b0;
      move_target       = lens_position;
      swap_pos          = '0;

      if (opcode == afs_pkg::OP_STOP) begin
         ctrl_next.mode       = afs_pkg::MODE_NOT_FOCUSED;
         ctrl_next.second_set = 1'b0;
         first_sharp_next     = '0;
         first_pos_next       = '0;
         second_sharp_next    = '0;
         second_pos_next      = '0;
         peak_sharp_next      = '0;
         peak_pos_next        = '0;
      end else begin
         case (ctrl.mode)
            afs_pkg::MODE_COARSE: begin
               if (sharpness > first_sharp) begin
                  second_sharp_next    = first_sharp;
                  second_pos_next      = first_pos;
                  ctrl_next.second_set = 1'b1;
                  first_sharp_next     = sharpness;
                  first_pos_next       = lens_position;
               end else if (sharpness < first_sharp &&
                            (!ctrl.second_set || sharpness > second_sharp)) begin
                  second_sharp_next    = sharpness;
                  second_pos_next      = lens_position;
                  ctrl_next.second_set = 1'b1;
               end
               move_valid = 1'b1;
               if (lens_position >= end_position) begin
                  ctrl_next.mode = afs_pkg::MODE_FINE;
                  if (second_pos_next < first_pos_next) begin
                     swap_pos        = second_pos_next;
                     second_pos_next = first_pos_next;
                     first_pos_next  = swap_pos;
                  end
                  move_target = first_pos_next;
               end else begin
                  move_target = coarse_next_pos;
               end
            end
            afs_pkg::MODE_FINE, afs_pkg::MODE_REFOCUS: begin
               move_valid = 1'b1;
               if (sharpness > peak_sharp) begin
                  peak_sharp_next = sharpness;
                  peak_pos_next   = lens_position;
               end
               if (lens_position >= second_pos) begin
                  ctrl_next.mode = afs_pkg::MODE_HOLDING;
                  move_target    = peak_pos_next;
               end else begin
                  move_target = fine_next_pos;
               end
            end
            afs_pkg::MODE_HOLDING: begin
               if (hold_outside) begin
                  ctrl_next.mode  = afs_pkg::MODE_REFOCUS;
                  peak_sharp_next = '0;
                  peak_pos_next   = '0;
                  move_valid      = 1'b1;
                  move_target     = first_pos;
               end
            end
            default: begin
               if (lens_position == '0) begin
                  ctrl_next.mode = afs_pkg::MODE_COARSE;
               end else begin
                  ctrl_next.mode = afs_pkg::MODE_NOT_FOCUSED;
                  move_valid     = 1'b1;
                  move_target    = '0;
               end
            end
         endcase
      end
   end

endmodule

// ----- design/contrast_autofocus_search.sv -----
// channel  | direction | handshake          | payload
// req      | in        | req_valid/req_stall | req_opcode, req_sharpness, req_lens_position
// rsp      | out       | rsp_valid/rsp_stall | rsp_move_valid, rsp_move_target, rsp_mode,
//          |           |                     | rsp_best_position
// csr      | in        | csr_write           | csr_index, csr_wdata
//
// One beat per cycle sustained while rsp_stall is low; a request beat passes through the input
// register and then the response register around the step logic.
// Synchronous active-high reset clears the search to not focused and loads register defaults.
// req_stall rises only when both stages are full and rsp_stall is high.
module contrast_autofocus_search #(
   parameter int POSITION_WIDTH  = 16,
   parameter int SHARPNESS_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [SHARPNESS_WIDTH-1:0]           req_sharpness,
   input  logic [POSITION_WIDTH-1:0]            req_lens_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_move_valid,
   output logic [afs_pkg::OUT_POS_WIDTH-1:0]    rsp_move_target,
   output logic [afs_pkg::MODE_CODE_WIDTH-1:0]  rsp_mode,
   output logic [afs_pkg::OUT_POS_WIDTH-1:0]    rsp_best_position,
   input  logic                                 csr_write,
   input  logic [afs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [afs_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [afs_pkg::CSR_DATA_WIDTH-1:0] end_position_ff;
   logic [afs_pkg::CSR_DATA_WIDTH-1:0] coarse_step_ff;
   logic [afs_pkg::CSR_DATA_WIDTH-1:0] fine_step_ff;
   logic [afs_pkg::TOL_WIDTH-1:0]      hold_tolerance_ff;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_opcode_ff;
   logic [SHARPNESS_WIDTH-1:0] s1_sharpness_ff;
   logic [POSITION_WIDTH-1:0]  s1_position_ff;

   afs_pkg::search_ctrl_type   ctrl_ff;
   afs_pkg::search_ctrl_type   ctrl_in;
   logic [SHARPNESS_WIDTH-1:0] first_sharp_ff;
   logic [SHARPNESS_WIDTH-1:0] first_sharp_in;
   logic [POSITION_WIDTH-1:0]  first_pos_ff;
   logic [POSITION_WIDTH-1:0]  first_pos_in;
   logic [SHARPNESS_WIDTH-1:0] second_sharp_ff;
   logic [SHARPNESS_WIDTH-1:0] second_sharp_in;
   logic [POSITION_WIDTH-1:0]  second_pos_ff;
   logic [POSITION_WIDTH-1:0]  second_pos_in;
   logic [SHARPNESS_WIDTH-1:0] peak_sharp_ff;
   logic [SHARPNESS_WIDTH-1:0] peak_sharp_in;
   logic [POSITION_WIDTH-1:0]  peak_pos_ff;
   logic [POSITION_WIDTH-1:0]  peak_pos_in;

   logic                       step_move_valid;
   logic [POSITION_WIDTH-1:0]  step_move_target;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 rsp_move_valid_ff;
   logic [afs_pkg::OUT_POS_WIDTH-1:0]    rsp_move_target_ff;
   logic [afs_pkg::MODE_CODE_WIDTH-1:0]  rsp_mode_ff;
   logic [afs_pkg::OUT_POS_WIDTH-1:0]    rsp_best_position_ff;

   logic rsp_ready;
   logic req_accept;
   logic s1_advance;

   assign rsp_ready   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = s1_valid_ff && rsp_ready;
   assign req_stall   = s1_valid_ff && !rsp_ready;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         end_position_ff   <= afs_pkg::END_POSITION_RESET;
         coarse_step_ff    <= afs_pkg::COARSE_STEP_RESET;
         fine_step_ff      <= afs_pkg::FINE_STEP_RESET;
         hold_tolerance_ff <= afs_pkg::HOLD_TOLERANCE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            afs_pkg::CSR_END_POSITION:   end_position_ff   <= csr_wdata;
            afs_pkg::CSR_COARSE_STEP:    coarse_step_ff    <= csr_wdata;
            afs_pkg::CSR_FINE_STEP:      fine_step_ff      <= csr_wdata;
            afs_pkg::CSR_HOLD_TOLERANCE: hold_tolerance_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff    <= req_opcode;
         s1_sharpness_ff <= req_sharpness;
         s1_position_ff  <= req_lens_position;
      end
   end

   afs_step #(
      .POSITION_WIDTH  (POSITION_WIDTH),
      .SHARPNESS_WIDTH (SHARPNESS_WIDTH)
   ) u_step (
      .opcode            (s1_opcode_ff),
      .sharpness         (s1_sharpness_ff),
      .lens_position     (s1_position_ff),
      .end_position      (POSITION_WIDTH'(end_position_ff)),
      .coarse_step       (POSITION_WIDTH'(coarse_step_ff)),
      .fine_step         (POSITION_WIDTH'(fine_step_ff)),
      .hold_tolerance    (hold_tolerance_ff),
      .ctrl              (ctrl_ff),
      .first_sharp       (first_sharp_ff),
      .first_pos         (first_pos_ff),
      .second_sharp      (second_sharp_ff),
      .second_pos        (second_pos_ff),
      .peak_sharp        (peak_sharp_ff),
      .peak_pos          (peak_pos_ff),
      .ctrl_next         (ctrl_in),
      .first_sharp_next  (first_sharp_in),
      .first_pos_next    (first_pos_in),
      .second_sharp_next (second_sharp_in),
      .second_pos_next   (second_pos_in),
      .peak_sharp_next   (peak_sharp_in),
      .peak_pos_next     (peak_pos_in),
      .move_valid        (step_move_valid),
      .move_target       (step_move_target)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.mode       <= afs_pkg::MODE_NOT_FOCUSED;
         ctrl_ff.second_set <= 1'b0;
         first_sharp_ff     <= '0;
         first_pos_ff       <= '0;
         second_sharp_ff    <= '0;
         second_pos_ff      <= '0;
         peak_sharp_ff      <= '0;
         peak_pos_ff        <= '0;
      end else if (s1_advance) begin
         ctrl_ff         <= ctrl_in;
         first_sharp_ff  <= first_sharp_in;
         first_pos_ff    <= first_pos_in;
         second_sharp_ff <= second_sharp_in;
         second_pos_ff   <= second_pos_in;
         peak_sharp_ff   <= peak_sharp_in;
         peak_pos_ff     <= peak_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_move_valid_ff    <= step_move_valid;
         rsp_move_target_ff   <= afs_pkg::OUT_POS_WIDTH'(step_move_target);
         rsp_mode_ff          <= afs_pkg::mode_code(ctrl_in.mode);
         rsp_best_position_ff <= afs_pkg::OUT_POS_WIDTH'(peak_pos_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_move_valid    = rsp_move_valid_ff;
   assign rsp_move_target   = rsp_move_target_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_best_position = rsp_best_position_ff;

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_opcode_ff == afs_pkg::OP_STOP) |=>
         (rsp_mode_ff == afs_pkg::MODE_CODE_NOT_FOCUSED && !rsp_move_valid_ff &&
          rsp_best_position_ff == '0))
      else $error("stop beat did not clear the search");

   a_s1_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_sharpness_ff)))
      else $error("held request beat lost");

   a_hold_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_move_valid_ff && rsp_mode_ff == afs_pkg::MODE_CODE_HOLDING) |->
         (rsp_move_target_ff == rsp_best_position_ff))
      else $error("hold entry target differs from best position");

   a_home_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_move_valid_ff && rsp_mode_ff == afs_pkg::MODE_CODE_NOT_FOCUSED)
         |-> (rsp_move_target_ff == '0))
      else $error("not focused move does not target home");

endmodule

// ----- tb/tb_contrast_autofocus_search.sv -----
`timescale 1ns / 100ps

module tb_contrast_autofocus_search;

   localparam int POS_W   = 16;
   localparam int SHARP_W = 32;
   localparam longint SHARP_MAX = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic               op;
      logic [SHARP_W-1:0] sharpness;
      logic [POS_W-1:0]   lens_pos;
   } frame_item_type;

   typedef struct packed {
      logic                                move_valid;
      logic [afs_pkg::OUT_POS_WIDTH-1:0]   target;
      logic [afs_pkg::MODE_CODE_WIDTH-1:0] mode;
      logic [afs_pkg::OUT_POS_WIDTH-1:0]   best_pos;
   } move_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_opcode = afs_pkg::OP_FRAME;
   logic [SHARP_W-1:0]                  req_sharpness = '0;
   logic [POS_W-1:0]                    req_lens_position = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_move_valid;
   logic [afs_pkg::OUT_POS_WIDTH-1:0]   rsp_move_target;
   logic [afs_pkg::MODE_CODE_WIDTH-1:0] rsp_mode;
   logic [afs_pkg::OUT_POS_WIDTH-1:0]   rsp_best_position;
   logic                                csr_write = 1'b0;
   logic [afs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = afs_pkg::CSR_END_POSITION;
   logic [afs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   frame_item_type  pending_frames[$];
   move_result_type expected_moves[$];
   int              frames_queued = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   logic            hold_start = 1'b0;
   int              hold_left;
   bit              failed = 1'b0;

   // predictor state and register copies
   logic [afs_pkg::CSR_DATA_WIDTH-1:0]  cfg_end_pos     = afs_pkg::END_POSITION_RESET;
   logic [afs_pkg::CSR_DATA_WIDTH-1:0]  cfg_coarse_step = afs_pkg::COARSE_STEP_RESET;
   logic [afs_pkg::CSR_DATA_WIDTH-1:0]  cfg_fine_step   = afs_pkg::FINE_STEP_RESET;
   logic [afs_pkg::TOL_WIDTH-1:0]       cfg_hold_tol    = afs_pkg::HOLD_TOLERANCE_RESET;
   logic [afs_pkg::MODE_CODE_WIDTH-1:0] focus_mode;
   logic [SHARP_W-1:0]                  lead_sharpness;
   logic [POS_W-1:0]                    lead_pos;
   logic signed [SHARP_W:0]             runner_sharpness;
   logic [POS_W-1:0]                    runner_pos;
   logic [SHARP_W-1:0]                  best_sharpness;
   logic [POS_W-1:0]                    best_pos;

   contrast_autofocus_search #(
      .POSITION_WIDTH(POS_W),
      .SHARPNESS_WIDTH(SHARP_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_sharpness(req_sharpness),
      .req_lens_position(req_lens_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_move_valid(rsp_move_valid),
      .rsp_move_target(rsp_move_target),
      .rsp_mode(rsp_mode),
      .rsp_best_position(rsp_best_position),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void restart_search();
      focus_mode       = afs_pkg::MODE_CODE_NOT_FOCUSED;
      lead_sharpness   = '0;
      lead_pos         = '0;
      runner_sharpness = '1;
      runner_pos       = '0;
      best_sharpness   = '0;
      best_pos         = '0;
   endfunction

   function automatic logic [POS_W-1:0] saturating_step(input logic [POS_W-1:0] p,
                                                        input logic [POS_W-1:0] st);
      logic [POS_W:0] sum;
      sum = {1'b0, p} + {1'b0, st};
      return sum[POS_W] ? '1 : sum[POS_W-1:0];
   endfunction

   function automatic move_result_type autofocus_step(input frame_item_type f);
      move_result_type  r;
      logic [63:0]      diff;
      logic [POS_W-1:0] swap_pos;
      r.move_valid = 1'b0;
      r.target     = f.lens_pos;
      if (f.op == afs_pkg::OP_STOP) begin
         restart_search();
      end else begin
         case (focus_mode)
            afs_pkg::MODE_CODE_COARSE: begin
               if (f.sharpness > lead_sharpness) begin
                  runner_sharpness = $signed({1'b0, lead_sharpness});
                  runner_pos       = lead_pos;
                  lead_sharpness   = f.sharpness;
                  lead_pos         = f.lens_pos;
               end else if (f.sharpness < lead_sharpness) begin
                  if ($signed({1'b0, f.sharpness}) > runner_sharpness) begin
                     runner_sharpness = $signed({1'b0, f.sharpness});
                     runner_pos       = f.lens_pos;
                  end
               end
               r.move_valid = 1'b1;
               if (f.lens_pos >= cfg_end_pos) begin
                  focus_mode = afs_pkg::MODE_CODE_FINE;
                  if (runner_pos < lead_pos) begin
                     swap_pos   = runner_pos;
                     runner_pos = lead_pos;
                     lead_pos   = swap_pos;
                  end
                  r.target = lead_pos;
               end else begin
                  r.target = saturating_step(f.lens_pos, cfg_coarse_step);
               end
            end
            afs_pkg::MODE_CODE_FINE, afs_pkg::MODE_CODE_REFOCUS: begin
               r.move_valid = 1'b1;
               if (f.sharpness > best_sharpness) begin
                  best_sharpness = f.sharpness;
                  best_pos       = f.lens_pos;
               end
               if (f.lens_pos >= runner_pos) begin
                  focus_mode = afs_pkg::MODE_CODE_HOLDING;
                  r.target   = best_pos;
               end else begin
                  r.target = saturating_step(f.lens_pos, cfg_fine_step);
               end
            end
            afs_pkg::MODE_CODE_HOLDING: begin
               diff = (f.sharpness >= best_sharpness) ? 64'(f.sharpness - best_sharpness)
                                                      : 64'(best_sharpness - f.sharpness);
               if ((diff << 16) > 64'(best_sharpness) * 64'(cfg_hold_tol)) begin
                  focus_mode     = afs_pkg::MODE_CODE_REFOCUS;
                  best_sharpness = '0;
                  best_pos       = '0;
                  r.move_valid   = 1'b1;
                  r.target       = lead_pos;
               end
            end
            default: begin
               focus_mode = afs_pkg::MODE_CODE_NOT_FOCUSED;
               if (f.lens_pos == '0) begin
                  focus_mode = afs_pkg::MODE_CODE_COARSE;
               end else begin
                  r.move_valid = 1'b1;
                  r.target     = '0;
               end
            end
         endcase
      end
      r.mode     = focus_mode;
      r.best_pos = best_pos;
      return r;
   endfunction

   // driver: present the oldest pending frame, hold it while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_moves.push_back(autofocus_step(pending_frames.pop_front()));
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (pending_frames.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid         <= 1'b1;
            req_opcode        <= pending_frames[0].op;
            req_sharpness     <= pending_frames[0].sharpness;
            req_lens_position <= pending_frames[0].lens_pos;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= 300;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // monitor: compare each move beat with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin : check_beat
         move_result_type want;
         if (expected_moves.size() == 0) begin
            $error("unexpected move beat: target %0d mode %0d", rsp_move_target, rsp_mode);
            failed = 1'b1;
         end else begin
            want = expected_moves.pop_front();
            if (rsp_move_valid !== want.move_valid) begin
               $error("move_valid: expected %0d, actual %0d", want.move_valid, rsp_move_valid);
               failed = 1'b1;
            end
            if (rsp_move_target !== want.target) begin
               $error("move_target: expected %0d, actual %0d", want.target, rsp_move_target);
               failed = 1'b1;
            end
            if (rsp_mode !== want.mode) begin
               $error("mode: expected %0d, actual %0d", want.mode, rsp_mode);
               failed = 1'b1;
            end
            if (rsp_best_position !== want.best_pos) begin
               $error("best_position: expected %0d, actual %0d", want.best_pos,
                      rsp_best_position);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic logic [SHARP_W-1:0] clamp_sharpness(input longint v);
      if (v < 0) return '0;
      if (v > SHARP_MAX) return '1;
      return v[SHARP_W-1:0];
   endfunction

   function automatic logic [SHARP_W-1:0] hill_sharpness(input int p, input int center,
                                                         input longint peak_val,
                                                         input longint slope);
      longint offset;
      longint v;
      offset = (p > center) ? p - center : center - p;
      v = peak_val - offset * slope;
      if (v < 0) v = 0;
      if ($urandom_range(0, 3) == 0) v = v + longint'($urandom_range(0, 30)) - 15;
      return clamp_sharpness(v);
   endfunction

   task automatic queue_frame(input frame_item_type f);
      pending_frames.push_back(f);
      frames_queued++;
   endtask

   task automatic write_register(input logic [afs_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [afs_pkg::CSR_DATA_WIDTH-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         afs_pkg::CSR_END_POSITION:   cfg_end_pos     = val;
         afs_pkg::CSR_COARSE_STEP:    cfg_coarse_step = val;
         afs_pkg::CSR_FINE_STEP:      cfg_fine_step   = val;
         afs_pkg::CSR_HOLD_TOLERANCE: cfg_hold_tol    = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(input int end_pos, input int coarse, input int fine,
                                input int tol);
      write_register(afs_pkg::CSR_END_POSITION, afs_pkg::CSR_DATA_WIDTH'(end_pos));
      write_register(afs_pkg::CSR_COARSE_STEP, afs_pkg::CSR_DATA_WIDTH'(coarse));
      write_register(afs_pkg::CSR_FINE_STEP, afs_pkg::CSR_DATA_WIDTH'(fine));
      write_register(afs_pkg::CSR_HOLD_TOLERANCE, afs_pkg::CSR_DATA_WIDTH'(tol));
   endtask

   // stop, leave not focused, coarse sweep over a hill, then fine sweeps each followed by hold frames
   task automatic queue_session();
      frame_item_type scan[$];
      int span, center, width, stride, p, passes, cut;
      longint peak_val, slope, top, s, band;
      span   = int'(cfg_end_pos);
      center = $urandom_range(0, span);
      case ($urandom_range(0, 3))
         0:       peak_val = SHARP_MAX;
         1:       peak_val = $urandom_range(0, 1000);
         default: peak_val = longint'($urandom);
      endcase
      width = $urandom_range(1, span + 1);
      slope = peak_val / width + 1;
      scan.push_back('{afs_pkg::OP_STOP, $urandom, POS_W'($urandom)});
      if ($urandom_range(0, 1) == 1)
         scan.push_back('{afs_pkg::OP_FRAME, $urandom, POS_W'($urandom_range(1, 65535))});
      scan.push_back('{afs_pkg::OP_FRAME, $urandom, '0});
      stride = span / $urandom_range(3, 10) + 1;
      if (stride < int'(cfg_coarse_step)) stride = int'(cfg_coarse_step);
      p = 0;
      forever begin
         scan.push_back('{afs_pkg::OP_FRAME, hill_sharpness(p, center, peak_val, slope),
                          POS_W'(p)});
         if (p >= span) break;
         p = (p + stride > 65535) ? 65535 : p + stride;
      end
      passes = $urandom_range(1, 2);
      repeat (passes) begin
         stride = span / $urandom_range(6, 14) + 1;
         if (stride < int'(cfg_fine_step)) stride = int'(cfg_fine_step);
         p   = $urandom_range(0, center);
         top = 0;
         forever begin
            s = hill_sharpness(p, center, peak_val, slope);
            if (s > top) top = s;
            scan.push_back('{afs_pkg::OP_FRAME, clamp_sharpness(s), POS_W'(p)});
            if (p >= span) break;
            p = (p + stride > 65535) ? 65535 : p + stride;
         end
         band = (top * longint'(cfg_hold_tol)) >> 16;
         repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 4))
               0:       s = top;
               1:       s = ($urandom_range(0, 1) == 1) ? top + band : top - band;
               2:       s = ($urandom_range(0, 1) == 1) ? top + band + 1 : top - band - 1;
               3:       s = longint'($urandom);
               default: s = top + longint'($urandom_range(0, 32)) - 16;
            endcase
            scan.push_back('{afs_pkg::OP_FRAME, clamp_sharpness(s), POS_W'(p)});
         end
      end
      cut = scan.size();
      if ($urandom_range(0, 99) < 15) cut = $urandom_range(1, scan.size());
      for (int i = 0; i < cut; i++) queue_frame(scan[i]);
   endtask

   task automatic queue_noise();
      frame_item_type f;
      repeat ($urandom_range(1, 6)) begin
         f.op = ($urandom_range(0, 7) == 0) ? afs_pkg::OP_STOP : afs_pkg::OP_FRAME;
         case ($urandom_range(0, 4))
            0:       f.sharpness = '0;
            1:       f.sharpness = '1;
            2:       f.sharpness = $urandom_range(0, 255);
            default: f.sharpness = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       f.lens_pos = '0;
            1:       f.lens_pos = '1;
            default: f.lens_pos = POS_W'($urandom);
         endcase
         queue_frame(f);
      end
   endtask

   task automatic run_phase(input int frames, input int send_pct, input int stall_pct,
                            input bit with_hold);
      int goal;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      goal = frames_queued + frames;
      while (frames_queued < goal) begin
         if ($urandom_range(0, 99) < 80) queue_session();
         else queue_noise();
      end
      if (with_hold) begin
         while (pending_frames.size() > 100) @(posedge clock);
         hold_start <= 1'b1;
         @(posedge clock);
         hold_start <= 1'b0;
      end
      while (pending_frames.size() != 0 || req_valid || expected_moves.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      restart_search();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_phase(280, 0, 0, 1'b1);

      load_settings(65535, 40000, 30000, 0);
      queue_frame('{afs_pkg::OP_STOP, 32'd0, 16'd0});
      queue_frame('{afs_pkg::OP_FRAME, 32'd5, 16'd123});
      queue_frame('{afs_pkg::OP_FRAME, 32'd9, 16'd0});
      queue_frame('{afs_pkg::OP_FRAME, 32'd100, 16'd0});
      queue_frame('{afs_pkg::OP_FRAME, 32'd100, 16'd30000});
      queue_frame('{afs_pkg::OP_FRAME, 32'd0, 16'd40000});
      queue_frame('{afs_pkg::OP_FRAME, 32'hFFFF_FFFF, 16'd50000});
      queue_frame('{afs_pkg::OP_FRAME, 32'd7, 16'd65535});
      queue_frame('{afs_pkg::OP_FRAME, 32'd10, 16'd0});
      queue_frame('{afs_pkg::OP_FRAME, 32'hFFFF_FFFF, 16'd40000});
      queue_frame('{afs_pkg::OP_FRAME, 32'd5, 16'd60000});
      queue_frame('{afs_pkg::OP_FRAME, 32'hFFFF_FFFF, 16'd60000});
      queue_frame('{afs_pkg::OP_FRAME, 32'hFFFF_FFFE, 16'd60000});
      queue_frame('{afs_pkg::OP_FRAME, 32'd3, 16'd0});
      queue_frame('{afs_pkg::OP_FRAME, 32'd3, 16'd50000});
      queue_frame('{afs_pkg::OP_FRAME, 32'd3, 16'd50000});
      queue_frame('{afs_pkg::OP_FRAME, 32'd0, 16'd50000});
      queue_frame('{afs_pkg::OP_STOP, 32'hFFFF_FFFF, 16'hFFFF});
      queue_frame('{afs_pkg::OP_FRAME, 32'd1, 16'd65535});
      queue_frame('{afs_pkg::OP_STOP, 32'd1, 16'd1});
      run_phase(240, 85, 0, 1'b0);

      load_settings(1, 1, 1, 65535);
      run_phase(240, 0, 85, 1'b0);

      load_settings(20000, 3000, 700, 3000);
      run_phase(260, 6, 6, 1'b0);

      load_settings(30000, 65535, 1, 40000);
      run_phase(260, 0, 0, 1'b0);

      repeat (8) @(posedge clock);
      if (!failed) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
